// ----- hw/rtl/c2u_pkg.sv -----
// Package for the charset to UTF-8 transcoder: mode codes, queue entry type,
// code page ROM functions. No dependencies.
package c2u_pkg;

  localparam logic [2:0] ModeUtf16Le = 3'd0;
  localparam logic [2:0] ModeUtf16Be = 3'd1;
  localparam logic [2:0] ModeLatin1  = 3'd2;
  localparam logic [2:0] ModeCp1251  = 3'd3;
  localparam logic [2:0] ModeKoi8r   = 3'd4;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;

  typedef struct packed {
    logic [2:0]  nbytes;   // 0..4
    logic [31:0] bytes;    // byte k at [8k+7:8k]
    logic        eos;
  } job_t;

  function automatic logic [15:0] cp1251_rom(input logic [6:0] a);
    logic [15:0] t [128];
    t = '{
      16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
      16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
      16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
      16'h0000, 16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F,
      16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7,
      16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
      16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7,
      16'h0451, 16'h2116, 16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457,
      16'h0410, 16'h0411, 16'h0412, 16'h0413, 16'h0414, 16'h0415, 16'h0416, 16'h0417,
      16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E, 16'h041F,
      16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0424, 16'h0425, 16'h0426, 16'h0427,
      16'h0428, 16'h0429, 16'h042A, 16'h042B, 16'h042C, 16'h042D, 16'h042E, 16'h042F,
      16'h0430, 16'h0431, 16'h0432, 16'h0433, 16'h0434, 16'h0435, 16'h0436, 16'h0437,
      16'h0438, 16'h0439, 16'h043A, 16'h043B, 16'h043C, 16'h043D, 16'h043E, 16'h043F,
      16'h0440, 16'h0441, 16'h0442, 16'h0443, 16'h0444, 16'h0445, 16'h0446, 16'h0447,
      16'h0448, 16'h0449, 16'h044A, 16'h044B, 16'h044C, 16'h044D, 16'h044E, 16'h044F
    };
    return t[a];
  endfunction

  function automatic logic [15:0] koi8r_rom(input logic [6:0] a);
    logic [15:0] t [128];
    t = '{
      16'h2500, 16'h2502, 16'h250C, 16'h2510, 16'h2514, 16'h2518, 16'h251C, 16'h2524,
      16'h252C, 16'h2534, 16'h253C, 16'h2580, 16'h2584, 16'h2588, 16'h258C, 16'h2590,
      16'h2591, 16'h2592, 16'h2593, 16'h2320, 16'h25A0, 16'h2219, 16'h221A, 16'h2248,
      16'h2264, 16'h2265, 16'h00A0, 16'h2321, 16'h00B0, 16'h00B2, 16'h00B7, 16'h00F7,
      16'h2550, 16'h2551, 16'h2552, 16'h0451, 16'h2553, 16'h2554, 16'h2555, 16'h2556,
      16'h2557, 16'h2558, 16'h2559, 16'h255A, 16'h255B, 16'h255C, 16'h255D, 16'h255E,
      16'h255F, 16'h2560, 16'h2561, 16'h0401, 16'h2562, 16'h2563, 16'h2564, 16'h2565,
      16'h2566, 16'h2567, 16'h2568, 16'h2569, 16'h256A, 16'h256B, 16'h256C, 16'h00A9,
      16'h044E, 16'h0430, 16'h0431, 16'h0446, 16'h0434, 16'h0435, 16'h0444, 16'h0433,
      16'h0445, 16'h0438, 16'h0439, 16'h043A, 16'h043B, 16'h043C, 16'h043D, 16'h043E,
      16'h043F, 16'h044F, 16'h0440, 16'h0441, 16'h0442, 16'h0443, 16'h0436, 16'h0432,
      16'h044C, 16'h044B, 16'h0437, 16'h0448, 16'h044D, 16'h0449, 16'h0447, 16'h044A,
      16'h042E, 16'h0410, 16'h0411, 16'h0426, 16'h0414, 16'h0415, 16'h0424, 16'h0413,
      16'h0425, 16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E,
      16'h041F, 16'h042F, 16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0416, 16'h0412,
      16'h042C, 16'h042B, 16'h0417, 16'h0428, 16'h042D, 16'h0429, 16'h0427, 16'h042A
    };
    return t[a];
  endfunction

endpackage

// ----- hw/rtl/charset_to_utf8_transcoder.sv -----
// Top level of the charset to UTF-8 transcoder: front end, job queue, back end.
// Depends on c2u_pkg, c2u_front, c2u_queue, c2u_back.
//
//  port group      dir  transfer when
//  unit/eos        in   push && !full
//  byte results    out  pop && !empty
//  source_mode     in   cfg_we_i
//
// One unit enters per cycle while the queue has room; the back end emits one
// byte per cycle while pop is high, up to four bytes per unit set by its UTF-8 length.
// Reset clears mode, surrogate/halt state and the queue. Either side may stall
// independently; the four-entry queue absorbs the difference.
module charset_to_utf8_transcoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [15:0] unit_i,
  input  logic        end_of_string_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        has_byte_o,
  output logic        last_of_run_o,
  output logic        string_end_o
);

  logic [2:0]    mode_q;
  c2u_pkg::job_t fjob, qjob;
  logic          qempty, qpop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= c2u_pkg::ModeUtf16Le;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  c2u_front u_front (
    .clk_i, .rst_ni, .mode_i(mode_q), .valid_i(push && !full),
    .unit_i, .eos_i(end_of_string_i), .job_o(fjob)
  );

  c2u_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .wdata_i(fjob), .full_o(full),
    .pop_i(qpop), .empty_o(qempty), .rdata_o(qjob)
  );

  c2u_back u_back (
    .clk_i, .rst_ni, .job_valid_i(!qempty), .job_i(qjob), .job_pop_o(qpop),
    .empty_o(empty), .pop_i(pop), .out_byte_o, .has_byte_o, .last_of_run_o,
    .string_end_o
  );

  a_marker_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !has_byte_o) |-> (last_of_run_o && string_end_o)) else $error("marker");
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && string_end_o) |-> last_of_run_o) else $error("string end");
  a_lead_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && $past(!empty && pop && last_of_run_o) && has_byte_o)
      |-> (out_byte_o[7:6] != 2'b10)) else $error("lead byte");

endmodule

// ----- hw/rtl/c2u_front.sv -----
// Front end: accepts units, tracks surrogate and halt state, encodes to UTF-8 bytes.
// Depends on c2u_pkg.
module c2u_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [2:0]      mode_i,
  input  logic            valid_i,
  input  logic [15:0]     unit_i,
  input  logic            eos_i,
  output c2u_pkg::job_t   job_o
);

  logic [9:0]  hi_q, hi_d;
  logic        pend_q, pend_d;
  logic        halt_q, halt_d;
  logic [15:0] u, cp;
  logic [7:0]  c;
  logic [20:0] sp;
  logic [2:0]  n;
  logic [31:0] b;
  logic        utf;

  always_comb begin
    pend_d = pend_q;
    hi_d   = hi_q;
    halt_d = halt_q;
    n      = 3'd0;
    b      = '0;
    cp     = 16'd0;
    sp     = 21'd0;
    c      = unit_i[7:0];
    utf    = (mode_i == c2u_pkg::ModeUtf16Le) || (mode_i == c2u_pkg::ModeUtf16Be);
    u      = (mode_i == c2u_pkg::ModeUtf16Be) ? {unit_i[7:0], unit_i[15:8]} : unit_i;
    if (!halt_q) begin
      if (utf) begin
        if (pend_q) begin
          pend_d = 1'b0;
          if (u[15:10] != 6'b110111) begin
            halt_d = 1'b1;
          end else begin
            sp = 21'h10000 + {1'b0, hi_q, u[9:0]};
            hi_d = 10'd0;
            n = 3'd4;
            b = {2'b10, sp[5:0], 2'b10, sp[11:6], 2'b10, sp[17:12], 5'b11110, sp[20:18]};
          end
        end else if (u == 16'd0) begin
          halt_d = 1'b1;
        end else if (u[15:10] == 6'b110110) begin
          hi_d = u[9:0];
          pend_d = 1'b1;
        end else begin
          cp = u;
          n = 3'd5;
        end
      end else begin
        pend_d = 1'b0;
        hi_d = 10'd0;
        if (c == 8'd0) begin
          halt_d = 1'b1;
        end else if (!c[7]) begin
          cp = {8'd0, c};
          n = 3'd5;
        end else if (mode_i == c2u_pkg::ModeCp1251) begin
          if (c != 8'h98) begin
            cp = c2u_pkg::cp1251_rom(c[6:0]);
            n = 3'd5;
          end
        end else if (mode_i == c2u_pkg::ModeKoi8r) begin
          cp = c2u_pkg::koi8r_rom(c[6:0]);
          n = 3'd5;
        end else begin
          cp = {8'd0, c};
          n = 3'd5;
        end
      end
    end
    if (n == 3'd5) begin
      if (cp < 16'h80) begin
        n = 3'd1;
        b = {24'd0, cp[7:0]};
      end else if (cp < 16'h800) begin
        n = 3'd2;
        b = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
      end else begin
        n = 3'd3;
        b = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
      end
    end
    if (eos_i) begin
      pend_d = 1'b0;
      hi_d = 10'd0;
      halt_d = 1'b0;
    end
  end

  assign job_o = '{nbytes: n, bytes: b, eos: eos_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q <= '0;
      pend_q <= 1'b0;
      halt_q <= 1'b0;
    end else if (valid_i) begin
      hi_q <= hi_d;
      pend_q <= pend_d;
      halt_q <= halt_d;
    end
  end

endmodule

// ----- hw/rtl/c2u_queue.sv -----
// Job queue between front and back end.
// Depends on c2u_pkg.
module c2u_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  c2u_pkg::job_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output c2u_pkg::job_t rdata_o
);

  c2u_pkg::job_t mem_q [c2u_pkg::QDepth];
  logic [c2u_pkg::QPtrW-1:0] wp_q, rp_q;
  logic [c2u_pkg::QPtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (c2u_pkg::QPtrW+1)'(c2u_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wp_q <= wp_q + 1'b1;
      if (pop_i && !empty_o) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (c2u_pkg::QPtrW+1)'(push_i && !full_o)
                     - (c2u_pkg::QPtrW+1)'(pop_i && !empty_o);
    end
  end

endmodule

// ----- hw/rtl/c2u_back.sv -----
// Back end: serializes one job into byte results, one per transfer.
// Depends on c2u_pkg.
module c2u_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  c2u_pkg::job_t job_i,
  output logic          job_pop_o,
  output logic          empty_o,
  input  logic          pop_i,
  output logic [7:0]    out_byte_o,
  output logic          has_byte_o,
  output logic          last_of_run_o,
  output logic          string_end_o
);

  logic [1:0] idx_q;
  logic       marker, drop, last;

  assign marker = (job_i.nbytes == 3'd0);
  // jobs with no bytes and no end mark give nothing
  assign drop   = job_valid_i && marker && !job_i.eos;
  assign empty_o = !job_valid_i || drop;
  assign last   = marker || ({1'b0, idx_q} == job_i.nbytes - 3'd1);
  assign out_byte_o    = job_i.bytes[{idx_q, 3'b000} +: 8];
  assign has_byte_o    = !marker;
  assign last_of_run_o = last;
  assign string_end_o  = last && job_i.eos;
  assign job_pop_o     = drop || (pop_i && !empty_o && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (pop_i && !empty_o) begin
      idx_q <= last ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule

// ----- dv/tb_charset_to_utf8_transcoder.sv -----
// Testbench for charset_to_utf8_transcoder: directed and random code units in
// every source mode, checked byte by byte against a built-in predictor.
// Depends on c2u_pkg and the transcoder RTL.
`timescale 1ns / 100ps

module tb_charset_to_utf8_transcoder;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last_of_run;
    logic       string_end;
  } utf8_res_t;

  class utf8_scoreboard;
    logic [2:0] mode;
    logic [9:0] held_bits;
    bit         held;
    bit         stopped;
    utf8_res_t  pending_bytes[$];
    int         errors;
    int         n_bytes;

    function void clear_state();
      mode = c2u_pkg::ModeUtf16Le;
      held_bits = '0;
      held = 0;
      stopped = 0;
      errors = 0;
      n_bytes = 0;
    endfunction

    function int encode_bmp(input logic [15:0] cp, ref logic [7:0] b[4]);
      if (cp < 16'h80) begin
        b[0] = cp[7:0];
        return 1;
      end
      if (cp < 16'h800) begin
        b[0] = 8'hC0 | cp[10:6];
        b[1] = 8'h80 | cp[5:0];
        return 2;
      end
      b[0] = 8'hE0 | cp[15:12];
      b[1] = 8'h80 | cp[11:6];
      b[2] = 8'h80 | cp[5:0];
      return 3;
    endfunction

    function void note_unit(input logic [15:0] unit, input bit eos);
      logic [7:0]  b[4];
      logic [15:0] u;
      logic [7:0]  c;
      logic [20:0] cp;
      int          n;
      utf8_res_t   r;
      n = 0;
      if (!stopped) begin
        if (mode == c2u_pkg::ModeUtf16Le || mode == c2u_pkg::ModeUtf16Be) begin
          u = (mode == c2u_pkg::ModeUtf16Be) ? {unit[7:0], unit[15:8]} : unit;
          if (held) begin
            held = 0;
            if (u < 16'hDC00 || u > 16'hDFFF) stopped = 1;
            else begin
              cp = 21'h10000 + {held_bits, u[9:0]};
              held_bits = '0;
              b[0] = 8'hF0 | cp[20:18];
              b[1] = 8'h80 | cp[17:12];
              b[2] = 8'h80 | cp[11:6];
              b[3] = 8'h80 | cp[5:0];
              n = 4;
            end
          end else if (u == 0) stopped = 1;
          else if (u >= 16'hD800 && u <= 16'hDBFF) begin
            held_bits = u[9:0];
            held = 1;
          end else n = encode_bmp(u, b);
        end else begin
          c = unit[7:0];
          held = 0;
          held_bits = '0;
          if (c == 0) stopped = 1;
          else if (c < 8'h80) n = encode_bmp({8'h00, c}, b);
          else if (mode == c2u_pkg::ModeCp1251) begin
            if (c != 8'h98) n = encode_bmp(cp1251_cp(c[6:0]), b);
          end else if (mode == c2u_pkg::ModeKoi8r) n = encode_bmp(koi8r_cp(c[6:0]), b);
          else n = encode_bmp({8'h00, c}, b);
        end
      end
      if (eos && held) begin
        held = 0;
        held_bits = '0;
        stopped = 1;
      end
      for (int k = 0; k < n; k++) begin
        r.out_byte = b[k];
        r.has_byte = 1;
        r.last_of_run = (k == n - 1);
        r.string_end = (k == n - 1) && eos;
        pending_bytes.push_back(r);
      end
      if (n == 0 && eos) pending_bytes.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
      if (eos) begin
        held = 0;
        held_bits = '0;
        stopped = 0;
      end
    endfunction

    function void check_byte(input utf8_res_t got);
      utf8_res_t want;
      n_bytes++;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      want = pending_bytes.pop_front();
      if (want.out_byte != got.out_byte)
        $display("%0t: out_byte exp %h got %h", $realtime, want.out_byte, got.out_byte);
      if (want.has_byte != got.has_byte)
        $display("%0t: has_byte exp %b got %b", $realtime, want.has_byte, got.has_byte);
      if (want.last_of_run != got.last_of_run)
        $display("%0t: last_of_run exp %b got %b", $realtime, want.last_of_run,
                 got.last_of_run);
      if (want.string_end != got.string_end)
        $display("%0t: string_end exp %b got %b", $realtime, want.string_end,
                 got.string_end);
      if (want != got) errors++;
    endfunction
  endclass

  // own code page tables, independent of the package functions
  logic [15:0] cp1251_tab[128] = '{
    16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
    16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h0000, 16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F,
    16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7,
    16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
    16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7,
    16'h0451, 16'h2116, 16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457,
    16'h0410, 16'h0411, 16'h0412, 16'h0413, 16'h0414, 16'h0415, 16'h0416, 16'h0417,
    16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E, 16'h041F,
    16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0424, 16'h0425, 16'h0426, 16'h0427,
    16'h0428, 16'h0429, 16'h042A, 16'h042B, 16'h042C, 16'h042D, 16'h042E, 16'h042F,
    16'h0430, 16'h0431, 16'h0432, 16'h0433, 16'h0434, 16'h0435, 16'h0436, 16'h0437,
    16'h0438, 16'h0439, 16'h043A, 16'h043B, 16'h043C, 16'h043D, 16'h043E, 16'h043F,
    16'h0440, 16'h0441, 16'h0442, 16'h0443, 16'h0444, 16'h0445, 16'h0446, 16'h0447,
    16'h0448, 16'h0449, 16'h044A, 16'h044B, 16'h044C, 16'h044D, 16'h044E, 16'h044F
  };
  logic [15:0] koi8r_tab[128] = '{
    16'h2500, 16'h2502, 16'h250C, 16'h2510, 16'h2514, 16'h2518, 16'h251C, 16'h2524,
    16'h252C, 16'h2534, 16'h253C, 16'h2580, 16'h2584, 16'h2588, 16'h258C, 16'h2590,
    16'h2591, 16'h2592, 16'h2593, 16'h2320, 16'h25A0, 16'h2219, 16'h221A, 16'h2248,
    16'h2264, 16'h2265, 16'h00A0, 16'h2321, 16'h00B0, 16'h00B2, 16'h00B7, 16'h00F7,
    16'h2550, 16'h2551, 16'h2552, 16'h0451, 16'h2553, 16'h2554, 16'h2555, 16'h2556,
    16'h2557, 16'h2558, 16'h2559, 16'h255A, 16'h255B, 16'h255C, 16'h255D, 16'h255E,
    16'h255F, 16'h2560, 16'h2561, 16'h0401, 16'h2562, 16'h2563, 16'h2564, 16'h2565,
    16'h2566, 16'h2567, 16'h2568, 16'h2569, 16'h256A, 16'h256B, 16'h256C, 16'h00A9,
    16'h044E, 16'h0430, 16'h0431, 16'h0446, 16'h0434, 16'h0435, 16'h0444, 16'h0433,
    16'h0445, 16'h0438, 16'h0439, 16'h043A, 16'h043B, 16'h043C, 16'h043D, 16'h043E,
    16'h043F, 16'h044F, 16'h0440, 16'h0441, 16'h0442, 16'h0443, 16'h0436, 16'h0432,
    16'h044C, 16'h044B, 16'h0437, 16'h0448, 16'h044D, 16'h0449, 16'h0447, 16'h044A,
    16'h042E, 16'h0410, 16'h0411, 16'h0426, 16'h0414, 16'h0415, 16'h0424, 16'h0413,
    16'h0425, 16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E,
    16'h041F, 16'h042F, 16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0416, 16'h0412,
    16'h042C, 16'h042B, 16'h0417, 16'h0428, 16'h042D, 16'h0429, 16'h0427, 16'h042A
  };

  function automatic logic [15:0] cp1251_cp(input logic [6:0] a);
    return cp1251_tab[a];
  endfunction

  function automatic logic [15:0] koi8r_cp(input logic [6:0] a);
    return koi8r_tab[a];
  endfunction

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_wdata_i = '0;
  logic        push = 0;
  logic        full;
  logic [15:0] unit_i = '0;
  logic        end_of_string_i = 0;
  logic        empty;
  logic        pop = 0;
  logic [7:0]  out_byte_o;
  logic        has_byte_o;
  logic        last_of_run_o;
  logic        string_end_o;

  utf8_scoreboard sb;
  bit  calm_rx;
  bit  hold_rx;
  int  n_units;

  charset_to_utf8_transcoder dut (.*);

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && !empty && pop)
      sb.check_byte('{out_byte_o, has_byte_o, last_of_run_o, string_end_o});
    if (!rst_ni || hold_rx) pop <= 0;
    else pop <= calm_rx || ($urandom_range(99) >= 14);
  end

  task automatic send_unit(input logic [15:0] u, input bit eos, input bit calm);
    if (!calm) begin
      while ($urandom_range(99) < 14) begin
        push <= 0;
        @(posedge clk_i);
      end
    end
    push <= 1;
    unit_i <= u;
    end_of_string_i <= eos;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_unit(u, eos);
    n_units++;
  endtask

  task automatic drain();
    push <= 0;
    while (sb.pending_bytes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic [2:0] m);
    drain();
    cfg_we_i <= 1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.mode = m;
  endtask

  function automatic logic [15:0] pick_unit(input logic [2:0] m);
    int r;
    r = $urandom_range(99);
    if (m > c2u_pkg::ModeUtf16Be)
      return {8'($urandom_range(255)), 8'($urandom_range(255))};
    if (r < 15) return 16'(32'hD800 + $urandom_range(16'h3FF));
    if (r < 30) return 16'(32'hDC00 + $urandom_range(16'h3FF));
    if (r < 33) return 16'h0000;
    return 16'($urandom_range(16'hFFFF));
  endfunction

  task automatic random_strings(input logic [2:0] m, input int count);
    logic [15:0] u;
    logic [15:0] hi;
    for (int i = 0; i < count; i++) begin
      u = pick_unit(m);
      if (m == c2u_pkg::ModeUtf16Be) u = {u[7:0], u[15:8]};
      // in the UTF-16 modes, 40 percent of the time send a well-formed surrogate pair
      if (m <= c2u_pkg::ModeUtf16Be && $urandom_range(99) < 40) begin
        hi = 16'(32'hD800 + $urandom_range(16'h3FF));
        u = 16'(32'hDC00 + $urandom_range(16'h3FF));
        if (m == c2u_pkg::ModeUtf16Be) begin
          hi = {hi[7:0], hi[15:8]};
          u = {u[7:0], u[15:8]};
        end
        send_unit(hi, 0, 0);
      end
      send_unit(u, ($urandom_range(99) < 15), 0);
    end
    send_unit(16'h0041, 1, 0);
  endtask

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    sb = new();
    sb.clear_state();
    calm_rx = 0;
    hold_rx = 0;
    n_units = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // UTF-16LE: extremes, pair, broken pair, lone low, zero halt, eos on high
    send_unit(16'h0041, 0, 1);
    send_unit(16'h07FF, 0, 1);
    send_unit(16'hFFFF, 0, 1);
    send_unit(16'hD800, 0, 1);
    send_unit(16'hDC00, 0, 1);
    send_unit(16'hDBFF, 0, 1);
    send_unit(16'hDFFF, 0, 1);
    send_unit(16'hDFFF, 0, 1);
    send_unit(16'hD812, 0, 1);
    send_unit(16'h0042, 0, 1);
    send_unit(16'h0043, 1, 1);
    send_unit(16'h0000, 0, 1);
    send_unit(16'h0044, 1, 1);
    send_unit(16'hD834, 1, 1);
    set_mode(c2u_pkg::ModeUtf16Be);
    send_unit(16'h3DD8, 0, 1);
    send_unit(16'h00DE, 1, 1);
    send_unit(16'hD800, 0, 1);
    set_mode(c2u_pkg::ModeLatin1);
    send_unit(16'hABFF, 0, 1);
    send_unit(16'h5500, 1, 1);
    set_mode(c2u_pkg::ModeCp1251);
    send_unit(16'h0098, 1, 1);
    send_unit(16'h00C0, 1, 1);
    set_mode(c2u_pkg::ModeKoi8r);
    send_unit(16'h0080, 0, 1);
    send_unit(16'h00FF, 1, 1);
    set_mode(3'd7);
    send_unit(16'h00E9, 1, 1);

    // fill the queue while the receiver stalls
    drain();
    hold_rx = 1;
    fork
      repeat (60) @(posedge clk_i);
      for (int i = 0; i < 10; i++) send_unit(16'h00C8, 0, 1);
    join_any
    hold_rx = 0;
    wait fork;
    send_unit(16'h0000, 1, 1);

    for (int p = 0; p < 7; p++) begin
      set_mode(p == 5 ? 3'd5 : (p == 6 ? c2u_pkg::ModeUtf16Le : 3'(p)));
      calm_rx = (p == 2);
      random_strings(sb.mode, 15);
    end
    calm_rx = 0;
    push <= 0;

    fork
      begin
        while (sb.pending_bytes.size() != 0) @(posedge clk_i);
        repeat (20) @(posedge clk_i);
      end
      begin
        repeat (200000) @(posedge clk_i);
        $display("%0t: drain timeout", $realtime);
        sb.errors++;
      end
    join_any
    disable fork;

    $display("covered %0d units in all five modes plus an unused code, %0d bytes checked",
             n_units, sb.n_bytes);
    if (sb.errors == 0 && sb.pending_bytes.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
